[rtl/connection_timer_bank_core_assert.svh]
// Assertion macros for the connection timer bank.
`ifndef CONNECTION_TIMER_BANK_CORE_ASSERT_SVH
`define CONNECTION_TIMER_BANK_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define CTB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CTB_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTB_ASSERT(lbl, clk, rst, prop, msg)
`define CTB_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

[rtl/ctb_pkg.sv]
`default_nettype none

package ctb_pkg;

   localparam logic [2:0] CMD_TICK     = 3'd0;
   localparam logic [2:0] CMD_SET      = 3'd1;
   localparam logic [2:0] CMD_SET_MIN1 = 3'd2;
   localparam logic [2:0] CMD_SET_MIN  = 3'd3;
   localparam logic [2:0] CMD_CANCEL   = 3'd4;
   localparam logic [2:0] CMD_OPEN     = 3'd5;
   localparam logic [2:0] CMD_CLOSE    = 3'd6;

   localparam int REQ_COUNT_W = 16;

   typedef struct packed {
      logic [2:0]             command;
      logic [2:0]             connection_index;
      logic [2:0]             timer_index;
      logic [REQ_COUNT_W-1:0] tick_count;
   } req_type;

   typedef struct packed {
      logic [2:0] expired_connection;
      logic [2:0] expired_timer;
      logic       last_of_tick;
   } rsp_type;

   typedef struct packed {
      logic write_en;
      logic expired;
   } alu_flags_type;

endpackage

`default_nettype wire

[rtl/connection_timer_bank_core.sv]
`default_nettype none
`include "connection_timer_bank_core_assert.svh"

// Bank of NUM_SLOTS x NUM_TIMERS countdown timers held in one on-chip memory, with an open
// flag per slot. One update unit serves the tick and every timer write. Set, set-or-lower
// and cancel read the memory on acceptance, then write back in ST_UPDATE; open, close, the
// unused command and a set or cancel aimed outside the bank finish in the idle state.
// A tick walks every timer of every slot, highest slot and timer first, one timer per
// cycle while the result channel does not hold it up, with the read of the next timer
// overlapping the write-back of the current one. Each expiry is held back by one so the
// final one can be marked last_of_tick. After reset the block clears all 2**AW entries of
// the memory, one entry a cycle, before it takes a transaction.
module connection_timer_bank_core #(
   parameter int NUM_SLOTS   = 8,
   parameter int NUM_TIMERS  = 6,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ctb_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ctb_pkg::rsp_type      rsp_data
);
   import ctb_pkg::*;

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int AW = SW + TW;
   localparam logic [SW-1:0] SLOT_TOP  = SW'(NUM_SLOTS - 1);
   localparam logic [TW-1:0] TIMER_TOP = TW'(NUM_TIMERS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   state_type              state_ff;
   logic [AW-1:0]          clr_addr_ff;
   logic [2:0]             cmd_ff;
   logic [AW-1:0]          upd_addr_ff;
   logic [COUNT_WIDTH-1:0] cnt_ff;
   logic [SW-1:0]          scan_slot_ff;
   logic [TW-1:0]          scan_timer_ff;
   logic                   pend_valid_ff;
   rsp_type                pend_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;
   logic [NUM_SLOTS-1:0]   slot_open_ff;

   logic [COUNT_WIDTH-1:0] req_cnt;
   logic [SW-1:0]          req_slot;
   logic [TW-1:0]          req_timer;
   logic                   slot_ok;
   logic                   timer_ok;
   logic                   req_accept;

   logic                   scan_last;
   logic [SW-1:0]          next_slot;
   logic [TW-1:0]          next_timer;
   logic                   slot_is_open;
   logic                   scan_hit;
   logic                   out_free;
   logic                   scan_go;
   logic                   rsp_load;

   logic [2:0]             alu_op;
   logic [COUNT_WIDTH-1:0] alu_result;
   alu_flags_type          alu_flags;

   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [COUNT_WIDTH-1:0] mem_wr_data;
   logic                   mem_rd_en;
   logic [AW-1:0]          mem_rd_addr;
   logic [COUNT_WIDTH-1:0] mem_rd_data;

   // Counts wider than the timers saturate at the largest count.
   generate
      if (COUNT_WIDTH >= REQ_COUNT_W) begin : g_cnt_wide
         assign req_cnt = COUNT_WIDTH'(req_data.tick_count);
      end else begin : g_cnt_sat
         assign req_cnt = (req_data.tick_count > REQ_COUNT_W'({COUNT_WIDTH{1'b1}})) ?
                          {COUNT_WIDTH{1'b1}} : req_data.tick_count[COUNT_WIDTH-1:0];
      end
   endgenerate

   assign req_slot   = SW'(req_data.connection_index);
   assign req_timer  = TW'(req_data.timer_index);
   assign slot_ok    = (int'(req_data.connection_index) < NUM_SLOTS);
   assign timer_ok   = (int'(req_data.timer_index) < NUM_TIMERS);
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign scan_last  = (scan_slot_ff == '0) && (scan_timer_ff == '0);
   assign next_slot  = (scan_timer_ff == '0) ? scan_slot_ff - SW'(1) : scan_slot_ff;
   assign next_timer = (scan_timer_ff == '0) ? TIMER_TOP : scan_timer_ff - TW'(1);

   assign slot_is_open = slot_open_ff[scan_slot_ff];
   assign scan_hit     = (state_ff == ST_SCAN) && slot_is_open && alu_flags.expired;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   // A new expiry can only be taken once the held one has somewhere to go.
   assign scan_go      = !scan_hit || !pend_valid_ff || out_free;
   assign rsp_load     = ((state_ff == ST_SCAN) && scan_go && scan_hit && pend_valid_ff) ||
                         ((state_ff == ST_FLUSH) && pend_valid_ff && out_free);

   assign alu_op = (state_ff == ST_SCAN) ? CMD_TICK : cmd_ff;

   ctb_alu #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_alu (
      .op       (alu_op),
      .old_count(mem_rd_data),
      .arg_count(cnt_ff),
      .result   (alu_result),
      .flags    (alu_flags)
   );

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = upd_addr_ff;
      mem_wr_data = alu_result;
      mem_rd_en   = 1'b0;
      mem_rd_addr = {next_slot, next_timer};
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = '0;
         end
         ST_IDLE: begin
            mem_rd_en   = req_accept;
            mem_rd_addr = (req_data.command == CMD_TICK) ? {SLOT_TOP, TIMER_TOP} :
                          {req_slot, req_timer};
         end
         ST_UPDATE: begin
            mem_wr_en = alu_flags.write_en;
         end
         ST_SCAN: begin
            mem_wr_en   = scan_go && slot_is_open && alu_flags.write_en;
            mem_wr_addr = {scan_slot_ff, scan_timer_ff};
            mem_rd_en   = scan_go && !scan_last;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   ctb_store #(
      .AW(AW),
      .DW(COUNT_WIDTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         slot_open_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
               if (clr_addr_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  cmd_ff        <= req_data.command;
                  upd_addr_ff   <= {req_slot, req_timer};
                  cnt_ff        <= req_cnt;
                  scan_slot_ff  <= SLOT_TOP;
                  scan_timer_ff <= TIMER_TOP;
                  if (req_data.command == CMD_TICK) begin
                     state_ff <= ST_SCAN;
                  end else if (req_data.command == CMD_OPEN) begin
                     if (slot_ok) begin
                        slot_open_ff[req_slot] <= 1'b1;
                     end
                  end else if (req_data.command == CMD_CLOSE) begin
                     if (slot_ok) begin
                        slot_open_ff[req_slot] <= 1'b0;
                     end
                  end else if (req_data.command inside
                               {CMD_SET, CMD_SET_MIN1, CMD_SET_MIN, CMD_CANCEL}) begin
                     if (slot_ok && timer_ok) begin
                        state_ff <= ST_UPDATE;
                     end
                  end
               end
            end
            ST_UPDATE: begin
               state_ff <= ST_IDLE;
            end
            ST_SCAN: begin
               if (scan_go) begin
                  if (scan_hit) begin
                     if (pend_valid_ff) begin
                        rsp_data_ff <= pend_ff;
                     end
                     pend_ff.expired_connection <= 3'(scan_slot_ff);
                     pend_ff.expired_timer      <= 3'(scan_timer_ff);
                     pend_ff.last_of_tick       <= 1'b0;
                     pend_valid_ff              <= 1'b1;
                  end
                  if (scan_last) begin
                     state_ff <= ST_FLUSH;
                  end else begin
                     scan_slot_ff  <= next_slot;
                     scan_timer_ff <= next_timer;
                  end
               end
            end
            ST_FLUSH: begin
               if (!pend_valid_ff) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  rsp_data_ff.expired_connection <= pend_ff.expired_connection;
                  rsp_data_ff.expired_timer      <= pend_ff.expired_timer;
                  rsp_data_ff.last_of_tick       <= 1'b1;
                  pend_valid_ff                  <= 1'b0;
                  state_ff                       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CTB_ASSERT_NR(a_clear_after_reset, clock, $past(reset) |-> req_stall, "transaction taken during clear")
   `CTB_ASSERT(a_rsp_from_tick, clock, reset, $rose(rsp_valid) |-> $past(state_ff == ST_SCAN || state_ff == ST_FLUSH), "result outside a tick")
   `CTB_ASSERT(a_no_pending_idle, clock, reset, (state_ff == ST_IDLE) |-> !pend_valid_ff, "held expiry left behind")
   `CTB_ASSERT(a_write_phase, clock, reset, mem_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_UPDATE || state_ff == ST_SCAN), "timer write in wrong phase")

endmodule

`default_nettype wire

[rtl/ctb_store.sv]
`default_nettype none

module ctb_store #(
   parameter int AW = 6,
   parameter int DW = 16
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [2**AW];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/ctb_alu.sv]
`default_nettype none

module ctb_alu #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic [2:0]             op,
   input  wire logic [COUNT_WIDTH-1:0] old_count,
   input  wire logic [COUNT_WIDTH-1:0] arg_count,
   output logic      [COUNT_WIDTH-1:0] result,
   output ctb_pkg::alu_flags_type      flags
);
   import ctb_pkg::*;

   logic                   old_zero;
   logic [COUNT_WIDTH-1:0] arg_floor;

   assign old_zero  = (old_count == '0);
   assign arg_floor = (arg_count == '0) ? COUNT_WIDTH'(1) : arg_count;

   always_comb begin
      result         = old_count;
      flags.write_en = 1'b0;
      flags.expired  = 1'b0;
      case (op)
         CMD_TICK: begin
            result         = old_count - COUNT_WIDTH'(1);
            flags.write_en = !old_zero;
            flags.expired  = (old_count == COUNT_WIDTH'(1));
         end
         CMD_SET: begin
            result         = arg_floor;
            flags.write_en = 1'b1;
         end
         CMD_SET_MIN1: begin
            result         = arg_floor;
            flags.write_en = old_zero || (old_count > arg_floor);
         end
         CMD_SET_MIN: begin
            result         = arg_count;
            flags.write_en = old_zero || (arg_count < old_count);
         end
         CMD_CANCEL: begin
            result         = '0;
            flags.write_en = 1'b1;
         end
         default: begin
            result         = old_count;
            flags.write_en = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

[bench/timer_expiry_checker.sv]
module timer_expiry_checker #(
   parameter int NUM_SLOTS  = 8,
   parameter int NUM_TIMERS = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire ctb_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire ctb_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    pending,
   output int                    expiries_seen
);
   import ctb_pkg::*;

   logic [15:0] count_q [NUM_SLOTS][NUM_TIMERS];
   logic        open_q  [NUM_SLOTS];
   rsp_type     expiry_queue [$];
   int          errors;
   int          seen;

   initial begin
      errors        = 0;
      seen          = 0;
      fail_count    = 0;
      pending       = 0;
      expiries_seen = 0;
   end

   // Applies one accepted transaction to the shadow timers and queues the expiries it causes.
   task automatic apply_command(input req_type item);
      int          s;
      int          t;
      logic [15:0] cnt;
      rsp_type     held;
      logic        have_held;
      have_held = 1'b0;
      held      = '0;
      s         = item.connection_index;
      t         = item.timer_index;
      // The count field is exactly the timer width, so it never needs saturating.
      cnt       = item.tick_count;
      if (item.command == CMD_TICK) begin
         // Each expiry is held back by one so that the final one of the tick can be marked.
         for (s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (open_q[s]) begin
               for (t = NUM_TIMERS - 1; t >= 0; t--) begin
                  if (count_q[s][t] != '0) begin
                     count_q[s][t] = count_q[s][t] - 16'd1;
                     if (count_q[s][t] == '0) begin
                        if (have_held)
                           expiry_queue.push_back(held);
                        held.expired_connection = 3'(s);
                        held.expired_timer      = 3'(t);
                        held.last_of_tick       = 1'b0;
                        have_held               = 1'b1;
                     end
                  end
               end
            end
         end
         if (have_held) begin
            held.last_of_tick = 1'b1;
            expiry_queue.push_back(held);
         end
      end else if (s < NUM_SLOTS) begin
         case (item.command)
            CMD_OPEN:  open_q[s] = 1'b1;
            CMD_CLOSE: open_q[s] = 1'b0;
            CMD_SET, CMD_SET_MIN1, CMD_SET_MIN, CMD_CANCEL: begin
               if (t < NUM_TIMERS) begin
                  case (item.command)
                     CMD_SET: begin
                        count_q[s][t] = (cnt == '0) ? 16'd1 : cnt;
                     end
                     CMD_SET_MIN1: begin
                        if (cnt == '0)
                           cnt = 16'd1;
                        if (count_q[s][t] == '0 || count_q[s][t] > cnt)
                           count_q[s][t] = cnt;
                     end
                     CMD_SET_MIN: begin
                        if (count_q[s][t] == '0 || cnt < count_q[s][t])
                           count_q[s][t] = cnt;
                     end
                     default: count_q[s][t] = '0;
                  endcase
               end
            end
            default: ;
         endcase
      end
   endtask

   always @(posedge clock) begin : watch
      int      s;
      int      t;
      rsp_type want;
      if (reset) begin
         for (s = 0; s < NUM_SLOTS; s++) begin
            open_q[s] = 1'b0;
            for (t = 0; t < NUM_TIMERS; t++)
               count_q[s][t] = '0;
         end
         expiry_queue.delete();
      end else begin
         // Results are checked before requests, so that an expiry can never be matched
         // against a tick accepted at the same edge.
         if (rsp_valid && !rsp_stall) begin
            seen++;
            if (expiry_queue.size() == 0) begin
               errors++;
               $display("%0t: expiry with none predicted: expected nothing, actual slot %0d timer %0d last %0b",
                        $time, rsp_data.expired_connection, rsp_data.expired_timer,
                        rsp_data.last_of_tick);
            end else begin
               want = expiry_queue.pop_front();
               if (rsp_data.expired_connection !== want.expired_connection) begin
                  errors++;
                  $display("%0t: expired_connection expected %0d actual %0d", $time,
                           want.expired_connection, rsp_data.expired_connection);
               end
               if (rsp_data.expired_timer !== want.expired_timer) begin
                  errors++;
                  $display("%0t: expired_timer expected %0d actual %0d", $time,
                           want.expired_timer, rsp_data.expired_timer);
               end
               if (rsp_data.last_of_tick !== want.last_of_tick) begin
                  errors++;
                  $display("%0t: last_of_tick expected %0b actual %0b", $time,
                           want.last_of_tick, rsp_data.last_of_tick);
               end
            end
         end
         if (req_valid && !req_stall)
            apply_command(req_data);
      end
      fail_count    <= errors;
      pending       <= expiry_queue.size();
      expiries_seen <= seen;
   end

endmodule

[bench/tb_top.sv]
module tb_top;
   import ctb_pkg::*;

   localparam logic [2:0] CMD_UNUSED = 3'd7;
   localparam int         LIMIT      = 400000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    hold_req;
   int      fail_count;
   int      pending;
   int      expiries_seen;
   int      idle_pct  = 29;
   int      stall_pct = 29;
   int      cycles    = 0;

   connection_timer_bank_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   timer_expiry_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .expiries_seen (expiries_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off once the stimulus asks for it.
   initial begin : result_side
      int   n;
      logic hold_taken;
      hold_taken = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            for (n = 0; n < 400; n++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic offer(input logic [2:0] op, input logic [2:0] slot,
                        input logic [2:0] tmr, input logic [15:0] cnt);
      req_type item;
      item.command          = op;
      item.connection_index = slot;
      item.timer_index      = tmr;
      item.tick_count       = cnt;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // Mostly small counts so that timers expire often, with the extremes mixed in.
   task automatic random_item();
      int          r;
      logic [2:0]  op;
      logic [2:0]  tmr;
      logic [15:0] cnt;
      r = $urandom_range(99);
      if (r < 30)
         op = CMD_TICK;
      else if (r < 45)
         op = CMD_SET;
      else if (r < 57)
         op = CMD_SET_MIN1;
      else if (r < 67)
         op = CMD_SET_MIN;
      else if (r < 75)
         op = CMD_CANCEL;
      else if (r < 87)
         op = CMD_OPEN;
      else if (r < 95)
         op = CMD_CLOSE;
      else
         op = CMD_UNUSED;
      tmr = ($urandom_range(99) < 90) ? 3'($urandom_range(5)) : 3'($urandom_range(7, 6));
      r = $urandom_range(99);
      if (r < 60)
         cnt = 16'($urandom_range(6, 1));
      else if (r < 68)
         cnt = '0;
      else if (r < 76)
         cnt = 16'hFFFF;
      else
         cnt = 16'($urandom_range(65535));
      offer(op, 3'($urandom_range(7)), tmr, cnt);
   endtask

   initial begin : stimulus
      int n;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      hold_req  <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // A tick with every slot closed must yield nothing.
      offer(CMD_TICK, 3'd0, 3'd0, 16'd0);
      offer(CMD_OPEN, 3'd7, 3'd0, 16'd0);
      offer(CMD_OPEN, 3'd0, 3'd0, 16'd0);
      offer(CMD_SET, 3'd7, 3'd5, 16'd0);
      offer(CMD_SET_MIN1, 3'd7, 3'd4, 16'd0);
      offer(CMD_SET_MIN, 3'd7, 3'd3, 16'd0);
      offer(CMD_SET, 3'd0, 3'd0, 16'hFFFF);
      offer(CMD_SET, 3'd0, 3'd5, 16'd2);
      offer(CMD_SET_MIN, 3'd0, 3'd5, 16'd5);
      offer(CMD_SET_MIN1, 3'd7, 3'd2, 16'd3);
      offer(CMD_SET_MIN1, 3'd7, 3'd2, 16'hFFFF);
      // Slot 3 is still closed: the write lands but the timer stays frozen.
      offer(CMD_SET, 3'd3, 3'd1, 16'd1);
      offer(CMD_SET, 3'd7, 3'd6, 16'd1);
      offer(CMD_CANCEL, 3'd7, 3'd7, 16'd0);
      offer(CMD_UNUSED, 3'd7, 3'd0, 16'd1);
      offer(CMD_TICK, 3'd0, 3'd0, 16'd0);
      offer(CMD_SET_MIN, 3'd0, 3'd5, 16'd1);
      offer(CMD_CLOSE, 3'd7, 3'd0, 16'd0);
      offer(CMD_TICK, 3'd0, 3'd0, 16'd0);
      offer(CMD_OPEN, 3'd3, 3'd0, 16'd0);
      offer(CMD_OPEN, 3'd7, 3'd0, 16'd0);
      offer(CMD_TICK, 3'd0, 3'd0, 16'd0);
      offer(CMD_CANCEL, 3'd0, 3'd0, 16'd0);
      offer(CMD_TICK, 3'd7, 3'd7, 16'hFFFF);

      for (n = 0; n < 100; n++)
         random_item();

      // A stretch with neither side idling.
      idle_pct  = 0;
      stall_pct = 0;
      for (n = 0; n < 50; n++)
         random_item();
      idle_pct  = 29;
      stall_pct = 29;

      // Arm plenty of short timers, then hold the result side off while ticks keep coming,
      // so that the block backs up and stalls its request side.
      for (n = 0; n < 8; n++)
         offer(CMD_OPEN, 3'(n), 3'd0, 16'd0);
      for (n = 0; n < 16; n++)
         offer(CMD_SET, 3'($urandom_range(7)), 3'($urandom_range(5)),
               16'($urandom_range(2, 1)));
      hold_req <= 1'b1;
      for (n = 0; n < 12; n++)
         offer((n % 3 == 0) ? CMD_TICK : CMD_SET, 3'($urandom_range(7)),
               3'($urandom_range(5)), 16'($urandom_range(3, 1)));

      for (n = 0; n < 70; n++)
         random_item();

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/ctb_pkg.sv
rtl/ctb_store.sv
rtl/ctb_alu.sv
rtl/connection_timer_bank_core.sv
bench/timer_expiry_checker.sv
bench/tb_top.sv
